@@ rtl/nal_length_prefixed_packet_scanner_assert.svh @@
// Assertion macros shared by the scanner's checker.
`ifndef NAL_LENGTH_PREFIXED_PACKET_SCANNER_ASSERT_SVH
`define NAL_LENGTH_PREFIXED_PACKET_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NLPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NLPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/nlps_pkg.sv @@
// Package: constants and codes of the length-prefixed NAL unit scanner.
`default_nettype none
package nlps_pkg;

   // Width of the unit length counter; lengths above its range are malformed.
   localparam int LENGTH_BITS = 32;
   localparam int ACCUM_BITS  = 32;
   localparam logic [ACCUM_BITS:0] LEN_MAX =
      (({{ACCUM_BITS{1'b0}}, 1'b1}) << LENGTH_BITS) - {{ACCUM_BITS{1'b0}}, 1'b1};

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CODEC_MODE   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PREFIX_BYTES = 1'd1;

   localparam logic CODEC_H264 = 1'b0;
   localparam logic CODEC_HEVC = 1'b1;

   localparam logic [2:0] PREFIX_MIN   = 3'd1;
   localparam logic [2:0] PREFIX_MAX   = 3'd4;
   localparam logic [2:0] PREFIX_RESET = 3'd4;

   // Parse phase codes
   localparam logic [1:0] PH_PREFIX = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;
   localparam logic [1:0] PH_SKIP   = 2'd3;

   // H.264 unit types
   localparam logic [4:0] AVC_IDR = 5'd5;
   localparam logic [4:0] AVC_SPS = 5'd7;
   localparam logic [4:0] AVC_PPS = 5'd8;

   // HEVC unit types
   localparam logic [5:0] HEVC_IRAP_FIRST = 6'd16;
   localparam logic [5:0] HEVC_IRAP_LAST  = 6'd23;
   localparam logic [5:0] HEVC_VPS        = 6'd32;
   localparam logic [5:0] HEVC_SPS        = 6'd33;
   localparam logic [5:0] HEVC_PPS        = 6'd34;

endpackage
`default_nettype wire

@@ rtl/nlps_if.sv @@
// Channel interfaces: packet byte input, packet result output, register writes.
`default_nettype none

interface nlps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nlps_rsp_if;
   logic valid;
   logic ready;
   logic well_formed;
   logic has_random_access;
   logic has_all_sets;

   modport source (output valid, output well_formed, output has_random_access,
                   output has_all_sets, input ready);
   modport sink (input valid, input well_formed, input has_random_access,
                 input has_all_sets, output ready);
endinterface

interface nlps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [nlps_pkg::CSR_INDEX_BITS-1:0] addr;
   logic [nlps_pkg::CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/nal_length_prefixed_packet_scanner.sv @@
// Length-prefixed NAL unit scanner: per-packet framing and unit type summary.
// Takes one packet byte per cycle while req ready is high and parses big-endian length prefixes of
// 1 to 4 bytes (register prefix_bytes; 0 acts as 1, 5 to 7 act as 4), decodes
// the header byte of each unit as H.264 or HEVC (register codec_mode), and on
// the byte flagged last_byte emits one result word: well_formed,
// has_random_access and has_all_sets (the last two read 0 on a malformed
// packet). Other bytes produce no result. Each byte updates the
// parse state registers; results sit in a one-word output register, and
// req ready drops only while that register holds a word the sink has not
// taken. A result appears on rsp in the cycle after its last byte is accepted.
// Register writes are always accepted and take effect on the next byte.
`default_nettype none
module nal_length_prefixed_packet_scanner (
   input  wire logic       clock,
   input  wire logic       reset,
   nlps_req_if.sink        req_chan,
   nlps_rsp_if.source      rsp_chan,
   nlps_csr_if.sink        csr_chan
);
   import nlps_pkg::*;

   // Configuration
   logic       codec_mode_ff, codec_mode_in;
   logic [2:0] prefix_bytes_ff, prefix_bytes_in;

   // Parse state
   logic [1:0]             phase_ff, phase_in, phase_nx;
   logic [1:0]             prefix_count_ff, prefix_count_in, prefix_count_nx;
   logic [ACCUM_BITS-1:0]  length_accum_ff, length_accum_in, length_accum_nx;
   logic [LENGTH_BITS-1:0] bytes_remaining_ff, bytes_remaining_in, bytes_remaining_nx;
   logic                   seen_ra_ff, seen_ra_in, seen_ra_nx;
   logic                   seen_vps_ff, seen_vps_in, seen_vps_nx;
   logic                   seen_sps_ff, seen_sps_in, seen_sps_nx;
   logic                   seen_pps_ff, seen_pps_in, seen_pps_nx;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   logic well_formed_ff, well_formed_in;
   logic has_ra_ff, has_ra_in;
   logic has_sets_ff, has_sets_in;

   logic                   accept;
   logic [2:0]             eff_prefix;
   logic [2:0]             have;
   logic [ACCUM_BITS-1:0]  accum_shift;
   logic                   length_bad;
   logic [LENGTH_BITS-1:0] remaining_dec;
   logic [4:0]             avc_type;
   logic [5:0]             hevc_type;
   logic                   ok;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (prefix_bytes_ff < PREFIX_MIN) begin
         eff_prefix = PREFIX_MIN;
      end else if (prefix_bytes_ff > PREFIX_MAX) begin
         eff_prefix = PREFIX_MAX;
      end else begin
         eff_prefix = prefix_bytes_ff;
      end
   end

   assign have          = {1'b0, prefix_count_ff} + 3'd1;
   assign accum_shift   = {length_accum_ff[ACCUM_BITS-9:0], req_chan.data_byte};
   assign length_bad    = (accum_shift == '0) || ({1'b0, accum_shift} > LEN_MAX);
   assign remaining_dec = bytes_remaining_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
   assign avc_type      = req_chan.data_byte[4:0];
   assign hevc_type     = req_chan.data_byte[6:1];

   // Next parse state for the byte on req
   always_comb begin
      phase_nx           = phase_ff;
      prefix_count_nx    = prefix_count_ff;
      length_accum_nx    = length_accum_ff;
      bytes_remaining_nx = bytes_remaining_ff;
      seen_ra_nx         = seen_ra_ff;
      seen_vps_nx        = seen_vps_ff;
      seen_sps_nx        = seen_sps_ff;
      seen_pps_nx        = seen_pps_ff;
      unique case (phase_ff) inside
         PH_PREFIX: begin
            length_accum_nx = accum_shift;
            if (have >= eff_prefix) begin
               prefix_count_nx = 2'd0;
               if (length_bad) begin
                  phase_nx = PH_SKIP;
               end else begin
                  phase_nx           = PH_HEADER;
                  bytes_remaining_nx = accum_shift[LENGTH_BITS-1:0];
               end
            end else begin
               prefix_count_nx = have[1:0];
            end
         end
         PH_HEADER, PH_BODY: begin
            if (phase_ff == PH_HEADER) begin
               if (codec_mode_ff == CODEC_H264) begin
                  if (avc_type == AVC_IDR) seen_ra_nx  = 1'b1;
                  if (avc_type == AVC_SPS) seen_sps_nx = 1'b1;
                  if (avc_type == AVC_PPS) seen_pps_nx = 1'b1;
               end else begin
                  if (hevc_type >= HEVC_IRAP_FIRST && hevc_type <= HEVC_IRAP_LAST) begin
                     seen_ra_nx = 1'b1;
                  end
                  if (hevc_type == HEVC_VPS) seen_vps_nx = 1'b1;
                  if (hevc_type == HEVC_SPS) seen_sps_nx = 1'b1;
                  if (hevc_type == HEVC_PPS) seen_pps_nx = 1'b1;
               end
            end
            bytes_remaining_nx = remaining_dec;
            if (remaining_dec == '0) begin
               phase_nx        = PH_PREFIX;
               prefix_count_nx = 2'd0;
               length_accum_nx = '0;
            end else begin
               phase_nx = PH_BODY;
            end
         end
         PH_SKIP: begin
            phase_nx = PH_SKIP;
         end
         default: begin
            phase_nx = PH_SKIP;
         end
      endcase
   end

   assign ok = (phase_nx == PH_PREFIX) && (prefix_count_nx == 2'd0);

   always_comb begin
      phase_in           = phase_ff;
      prefix_count_in    = prefix_count_ff;
      length_accum_in    = length_accum_ff;
      bytes_remaining_in = bytes_remaining_ff;
      seen_ra_in         = seen_ra_ff;
      seen_vps_in        = seen_vps_ff;
      seen_sps_in        = seen_sps_ff;
      seen_pps_in        = seen_pps_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            // packet done: clear for the next one
            phase_in           = PH_PREFIX;
            prefix_count_in    = 2'd0;
            length_accum_in    = '0;
            bytes_remaining_in = '0;
            seen_ra_in         = 1'b0;
            seen_vps_in        = 1'b0;
            seen_sps_in        = 1'b0;
            seen_pps_in        = 1'b0;
         end else begin
            phase_in           = phase_nx;
            prefix_count_in    = prefix_count_nx;
            length_accum_in    = length_accum_nx;
            bytes_remaining_in = bytes_remaining_nx;
            seen_ra_in         = seen_ra_nx;
            seen_vps_in        = seen_vps_nx;
            seen_sps_in        = seen_sps_nx;
            seen_pps_in        = seen_pps_nx;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      well_formed_in = well_formed_ff;
      has_ra_in      = has_ra_ff;
      has_sets_in    = has_sets_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && req_chan.last_byte) begin
         rsp_valid_in   = 1'b1;
         well_formed_in = ok;
         has_ra_in      = ok && seen_ra_nx;
         has_sets_in    = ok && (codec_mode_ff == CODEC_H264 || seen_vps_nx)
                          && seen_sps_nx && seen_pps_nx;
      end
   end

   always_comb begin
      codec_mode_in   = codec_mode_ff;
      prefix_bytes_in = prefix_bytes_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            REG_CODEC_MODE:   codec_mode_in   = csr_chan.wdata[0];
            REG_PREFIX_BYTES: prefix_bytes_in = csr_chan.wdata;
            default: begin
               codec_mode_in   = codec_mode_ff;
               prefix_bytes_in = prefix_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_mode_ff   <= CODEC_H264;
         prefix_bytes_ff <= PREFIX_RESET;
         phase_ff        <= PH_PREFIX;
         prefix_count_ff <= 2'd0;
         length_accum_ff <= '0;
         bytes_remaining_ff <= '0;
         seen_ra_ff      <= 1'b0;
         seen_vps_ff     <= 1'b0;
         seen_sps_ff     <= 1'b0;
         seen_pps_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         codec_mode_ff   <= codec_mode_in;
         prefix_bytes_ff <= prefix_bytes_in;
         phase_ff        <= phase_in;
         prefix_count_ff <= prefix_count_in;
         length_accum_ff <= length_accum_in;
         bytes_remaining_ff <= bytes_remaining_in;
         seen_ra_ff      <= seen_ra_in;
         seen_vps_ff     <= seen_vps_in;
         seen_sps_ff     <= seen_sps_in;
         seen_pps_ff     <= seen_pps_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      well_formed_ff <= well_formed_in;
      has_ra_ff      <= has_ra_in;
      has_sets_ff    <= has_sets_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.well_formed       = well_formed_ff;
   assign rsp_chan.has_random_access = has_ra_ff;
   assign rsp_chan.has_all_sets      = has_sets_ff;

endmodule
`default_nettype wire

@@ rtl/nlps_checker.sv @@
// Port-level checker for the scanner and its bind to the top level.
`default_nettype none
`include "nal_length_prefixed_packet_scanner_assert.svh"
module nlps_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_last_byte,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_well_formed,
   input wire logic rsp_has_random_access,
   input wire logic rsp_has_all_sets
);

   // a stalled word holds
   `NLPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_well_formed) && $stable(rsp_has_random_access) && $stable(rsp_has_all_sets), "rsp word changed while stalled")

   // a last byte yields a result word in the next cycle
   `NLPS_ASSERT_NEXT(a_last_gives_rsp, req_valid && req_ready && req_last_byte, rsp_valid, "no result after last byte")

   // a pending result blocks new bytes
   `NLPS_ASSERT_NOW(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready, "req accepted while result stalled")

   // summary bits are set only for a well-formed packet
   `NLPS_ASSERT_NOW(a_summary_needs_ok, rsp_valid && (rsp_has_random_access || rsp_has_all_sets), rsp_well_formed, "summary set on malformed packet")

endmodule

bind nal_length_prefixed_packet_scanner nlps_checker u_nlps_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_chan.valid),
   .req_ready             (req_chan.ready),
   .req_last_byte         (req_chan.last_byte),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_well_formed       (rsp_chan.well_formed),
   .rsp_has_random_access (rsp_chan.has_random_access),
   .rsp_has_all_sets      (rsp_chan.has_all_sets)
);
`default_nettype wire

@@ tb/tb_nal_length_prefixed_packet_scanner.sv @@
// Testbench for the length-prefixed NAL unit scanner: directed table, random packets, scoreboard.
module tb_nal_length_prefixed_packet_scanner;
   timeunit 1ns;
   timeprecision 1ps;

   import nlps_pkg::*;

   typedef struct packed {
      logic well_formed;
      logic has_random_access;
      logic has_all_sets;
   } summary_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_CODEC, ROW_PREFIX} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         last;
      logic         pinned;
      summary_type  pin;
   } directed_row_type;

   typedef enum int {
      BREAK_ZERO_LENGTH, BREAK_TRUNCATE, BREAK_TRAILING, BREAK_NOISE, BREAK_OVERRUN
   } break_kind_type;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 170;
   localparam int DIRECTED_ROWS = 30;

   // Pinned rows carry {well_formed, has_random_access, has_all_sets}.
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // reset setting: H.264, 4-byte prefix, one IDR unit
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h65, 1'b1, 1'b1, 3'b110},
      '{ROW_PREFIX, {5'd0, PREFIX_MIN}, 1'b0, 1'b0, 3'b000},
      // SPS then PPS
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h67, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h68, 1'b1, 1'b1, 3'b101},
      // zero length
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 3'b000},
      // unit runs past the packet end
      '{ROW_BYTE, 8'h03, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h65, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 3'b000},
      // prefix completes on the last byte
      '{ROW_BYTE, 8'h02, 1'b1, 1'b1, 3'b000},
      '{ROW_CODEC, {7'd0, CODEC_HEVC}, 1'b0, 1'b0, 3'b000},
      // HEVC VPS, SPS, PPS
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h40, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h42, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h44, 1'b1, 1'b1, 3'b101},
      '{ROW_PREFIX, 8'd3, 1'b0, 1'b0, 3'b000},
      // partial prefix at the end
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 3'b000},
      // HEVC type 23, top of the random-access range
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'b000},
      '{ROW_BYTE, 8'h2E, 1'b1, 1'b1, 3'b110}
   };

   logic clock;
   logic reset;

   nlps_req_if req_chan();
   nlps_rsp_if rsp_chan();
   nlps_csr_if csr_chan();

   nal_length_prefixed_packet_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Scanner mirror: configuration and per-packet parse state
   logic        cfg_codec;
   logic [2:0]  cfg_prefix;
   logic [1:0]  parse_phase;
   logic [1:0]  prefix_seen;
   logic [31:0] len_accum;
   logic [31:0] unit_left;
   logic        saw_irap;
   logic        saw_vps;
   logic        saw_sps;
   logic        saw_pps;
   logic        broken;

   summary_type expected_summaries[$];
   logic [7:0]  pkt_bytes[$];
   logic        pin_on;
   summary_type pin_res;

   int error_count;
   int cycle_count;
   int bytes_sent;
   int packets_sent;
   int results_checked;
   int clean_results;
   int settings_used;
   int send_idle_pct;
   int recv_stall_pct;

   function automatic int prefix_width(logic [2:0] cfg);
      if (cfg == 3'd0) return int'(PREFIX_MIN);
      if (cfg > PREFIX_MAX) return int'(PREFIX_MAX);
      return int'(cfg);
   endfunction

   function void restart_packet();
      parse_phase = PH_PREFIX;
      prefix_seen = '0;
      len_accum   = '0;
      unit_left   = '0;
      saw_irap    = 1'b0;
      saw_vps     = 1'b0;
      saw_sps     = 1'b0;
      saw_pps     = 1'b0;
      broken      = 1'b0;
   endfunction

   function void take_unit_byte();
      unit_left = unit_left - 32'd1;
      if (unit_left == '0) begin
         parse_phase = PH_PREFIX;
         prefix_seen = '0;
         len_accum   = '0;
      end else begin
         parse_phase = PH_BODY;
      end
   endfunction

   // Advance the mirror by one packet byte; returns 1 when a summary is due.
   function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                    output summary_type res);
      int   have;
      logic ok;
      res = '0;
      case (parse_phase)
         PH_PREFIX: begin
            len_accum = {len_accum[23:0], b};
            have = int'(prefix_seen) + 1;
            if (have >= prefix_width(cfg_prefix)) begin
               // a 32-bit length always fits the unit counter; only zero is bad
               if (len_accum == '0) begin
                  broken      = 1'b1;
                  parse_phase = PH_SKIP;
               end else begin
                  unit_left   = len_accum;
                  parse_phase = PH_HEADER;
                  prefix_seen = '0;
               end
            end else begin
               prefix_seen = 2'(have);
            end
         end
         PH_HEADER: begin
            if (cfg_codec == CODEC_H264) begin
               if (b[4:0] == AVC_IDR) saw_irap = 1'b1;
               if (b[4:0] == AVC_SPS) saw_sps = 1'b1;
               if (b[4:0] == AVC_PPS) saw_pps = 1'b1;
            end else begin
               if (b[6:1] >= HEVC_IRAP_FIRST && b[6:1] <= HEVC_IRAP_LAST) saw_irap = 1'b1;
               if (b[6:1] == HEVC_VPS) saw_vps = 1'b1;
               if (b[6:1] == HEVC_SPS) saw_sps = 1'b1;
               if (b[6:1] == HEVC_PPS) saw_pps = 1'b1;
            end
            take_unit_byte();
         end
         PH_BODY: take_unit_byte();
         default: ;
      endcase
      if (!last) return 1'b0;
      ok = !broken && parse_phase == PH_PREFIX && prefix_seen == '0;
      res.well_formed       = ok;
      res.has_random_access = ok && saw_irap;
      res.has_all_sets      = ok && (cfg_codec == CODEC_H264 || saw_vps) && saw_sps && saw_pps;
      restart_packet();
      return 1'b1;
   endfunction

   function void check_field(string name, logic exp, logic act);
      if (act !== exp) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, exp, act);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) cycle_count++;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d summaries outstanding",
               cycle_count, expected_summaries.size());
      $display("DONE: errors detected");
      $finish;
   end

   always @(negedge clock) rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);

   // Scoreboard: check results, track register writes, predict on accepted words
   always @(posedge clock) begin
      summary_type got;
      summary_type want;
      summary_type pred;
      if (reset) begin
         cfg_codec  = CODEC_H264;
         cfg_prefix = PREFIX_RESET;
         restart_packet();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.well_formed       = rsp_chan.well_formed;
            got.has_random_access = rsp_chan.has_random_access;
            got.has_all_sets      = rsp_chan.has_all_sets;
            if (expected_summaries.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result: expected none, actual %b", $time, got);
            end else begin
               want = expected_summaries.pop_front();
               check_field("well_formed", want.well_formed, got.well_formed);
               check_field("has_random_access", want.has_random_access,
                           got.has_random_access);
               check_field("has_all_sets", want.has_all_sets, got.has_all_sets);
               results_checked++;
               if (got.well_formed) clean_results++;
            end
         end
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.addr == REG_CODEC_MODE) cfg_codec = csr_chan.wdata[0];
            else if (csr_chan.addr == REG_PREFIX_BYTES) cfg_prefix = csr_chan.wdata;
         end
         if (req_chan.valid && req_chan.ready) begin
            if (scan_byte(req_chan.data_byte, req_chan.last_byte, pred))
               expected_summaries.push_back(pin_on ? pin_res : pred);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                            input summary_type pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.data_byte = b;
      req_chan.last_byte = last;
      pin_on             = pinned;
      pin_res            = pin;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Leaves valid high; the caller drops it after its last write.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_chan.valid = 1'b1;
      csr_chan.addr  = addr;
      csr_chan.wdata = data;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      if (expected_summaries.size() != 0) begin
         req_chan.valid = 1'b0;
         while (expected_summaries.size() != 0) @(negedge clock);
      end
   endtask

   // Bytes that produce no result may still be in flight: settle before writes.
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (expected_summaries.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_length(input int unsigned len, input int width);
      for (int i = width - 1; i >= 0; i--) pkt_bytes.push_back(8'(len >> (8 * i)));
   endtask

   function automatic logic [7:0] pick_header();
      int         sel;
      logic [4:0] avc_type;
      logic [5:0] hevc_type;
      if (cfg_codec == CODEC_H264) begin
         sel = $urandom_range(3);
         avc_type = (sel == 0) ? AVC_IDR : (sel == 1) ? AVC_SPS :
                    (sel == 2) ? AVC_PPS : 5'($urandom);
         return {3'($urandom), avc_type};
      end
      sel = $urandom_range(4);
      hevc_type = (sel == 0) ? 6'($urandom_range(HEVC_IRAP_FIRST, HEVC_IRAP_LAST)) :
                  (sel == 1) ? HEVC_VPS : (sel == 2) ? HEVC_SPS :
                  (sel == 3) ? HEVC_PPS : 6'($urandom);
      return {1'($urandom), hevc_type, 1'($urandom)};
   endfunction

   // Mostly well-framed packets with random content; a quarter get broken.
   task automatic build_packet();
      int             width;
      int             units;
      int             cut;
      int unsigned    len;
      break_kind_type how;
      pkt_bytes.delete();
      width = prefix_width(cfg_prefix);
      units = $urandom_range(1, 4);
      repeat (units) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
         push_length(len, width);
         pkt_bytes.push_back(pick_header());
         repeat (len - 1) pkt_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(99) < 25) begin
         how = break_kind_type'($urandom_range(4));
         case (how)
            BREAK_ZERO_LENGTH: begin
               push_length(0, width);
               repeat ($urandom_range(3)) pkt_bytes.push_back(8'($urandom));
            end
            BREAK_TRUNCATE: begin
               cut = $urandom_range(1, (pkt_bytes.size() > 4) ? 4 : pkt_bytes.size() - 1);
               repeat (cut) void'(pkt_bytes.pop_back());
            end
            BREAK_TRAILING: repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
            BREAK_NOISE: begin
               pkt_bytes.delete();
               repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom));
            end
            default: begin
               // length far beyond the bytes that follow
               pkt_bytes.delete();
               pkt_bytes.push_back(8'($urandom_range(128, 255)));
               repeat (width - 1) pkt_bytes.push_back(8'($urandom));
               repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      int         phase_start;
      logic       codec;
      logic [2:0] prefix;
      error_count        = 0;
      cycle_count        = 0;
      bytes_sent         = 0;
      packets_sent       = 0;
      results_checked    = 0;
      clean_results      = 0;
      settings_used      = 0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      pin_on             = 1'b0;
      pin_res            = '0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b1;
      csr_chan.valid     = 1'b0;
      csr_chan.addr      = '0;
      csr_chan.wdata     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_BYTE) begin
            send_byte(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].pinned,
                      DIRECTED[i].pin);
         end else begin
            wait_idle();
            write_reg((DIRECTED[i].kind == ROW_CODEC) ? REG_CODEC_MODE : REG_PREFIX_BYTES,
                      DIRECTED[i].value[CSR_DATA_BITS-1:0]);
            csr_chan.valid = 1'b0;
            settings_used++;
         end
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = (p == 1) ? 68 : (p == 3) ? 21 : 0;
         recv_stall_pct = (p == 2) ? 68 : (p == 3) ? 21 : 0;
         phase_start    = bytes_sent;
         for (int seg = 0; seg < 3; seg++) begin
            wait_idle();
            if (seg == 0) begin
               codec  = (p % 2 == 0) ? CODEC_H264 : CODEC_HEVC;
               prefix = (p == 0 || p == 3) ? PREFIX_MAX : PREFIX_MIN;
            end else begin
               codec  = 1'($urandom);
               prefix = 3'($urandom_range(0, 7));
            end
            write_reg(REG_CODEC_MODE, {{(CSR_DATA_BITS - 1){1'b0}}, codec});
            write_reg(REG_PREFIX_BYTES, prefix);
            csr_chan.valid = 1'b0;
            settings_used++;
            while (bytes_sent < phase_start + PHASE_ITEMS * (seg + 1) / 3) begin
               build_packet();
               foreach (pkt_bytes[i])
                  send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, '0);
               packets_sent++;
               // hold off until every summary is back
               if ($urandom_range(11) == 0) drain();
            end
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d packet bytes: directed table plus %0d random packets, %0d settings.",
               bytes_sent, packets_sent, settings_used);
      $display("Checked %0d summaries (%0d well formed) across gap and stall phases.",
               results_checked, clean_results);
      if (error_count == 0 && expected_summaries.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/nlps_pkg.sv
rtl/nlps_if.sv
rtl/nal_length_prefixed_packet_scanner.sv
rtl/nlps_checker.sv
tb/tb_nal_length_prefixed_packet_scanner.sv
